// ===== rtl/tidu_pkg.sv =====
// Shared types and constants of the trap and interrupt delegation unit.
package tidu_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned NUM_PRIV  = 4;
   localparam int unsigned NUM_IRQ   = 12;

   localparam logic [1:0] OP_TRAP      = 2'd0;
   localparam logic [1:0] OP_INT_CHECK = 2'd1;
   localparam logic [1:0] OP_LOAD      = 2'd2;

   localparam logic [1:0] PRIV_USER    = 2'd0;
   localparam logic [1:0] PRIV_SUPER   = 2'd1;
   localparam logic [1:0] PRIV_HYPER   = 2'd2;
   localparam logic [1:0] PRIV_MACHINE = 2'd3;

   localparam logic [2:0] CSR_MACH_EXC_DELEG = 3'd0;
   localparam logic [2:0] CSR_SUP_EXC_DELEG  = 3'd1;
   localparam logic [2:0] CSR_MACH_INT_DELEG = 3'd2;
   localparam logic [2:0] CSR_SUP_INT_DELEG  = 3'd3;
   localparam logic [2:0] CSR_MACH_VECTOR    = 3'd4;
   localparam logic [2:0] CSR_SUP_VECTOR     = 3'd5;
   localparam logic [2:0] CSR_USER_VECTOR    = 3'd6;

   localparam int unsigned ST_SIE  = 1;
   localparam int unsigned ST_MIE  = 3;
   localparam int unsigned ST_SPIE = 5;
   localparam int unsigned ST_MPIE = 7;
   localparam int unsigned ST_SPP  = 8;
   localparam int unsigned ST_MPP  = 11;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [4:0]            trap_cause;
      logic [XLEN-1:0]       trap_value;
      logic [XLEN-1:0]       current_pc;
      logic [NUM_IRQ-1:0]    pending_bits;
      logic [NUM_IRQ-1:0]    enable_bits;
      logic                  in_wfi;
      logic [XLEN-1:0]       load_status;
      logic [1:0]            load_priv;
   } req_type;

   typedef struct packed {
      logic                  taken;
      logic [1:0]            target_priv;
      logic [XLEN-1:0]       jump_pc;
      logic [XLEN-1:0]       saved_epc;
      logic [XLEN-1:0]       cause_word;
      logic [XLEN-1:0]       status_word;
   } rsp_type;

   typedef struct packed {
      logic [XLEN-1:0]       mach_exc_deleg;
      logic [XLEN-1:0]       sup_exc_deleg;
      logic [XLEN-1:0]       mach_int_deleg;
      logic [XLEN-1:0]       sup_int_deleg;
      logic [XLEN-1:0]       mach_vector;
      logic [XLEN-1:0]       sup_vector;
      logic [XLEN-1:0]       user_vector;
   } csr_type;

   typedef struct packed {
      logic [1:0]                          priv_level;
      logic [XLEN-1:0]                     status_reg;
      logic [NUM_PRIV-1:0][XLEN-1:0]       epc_bank;
      logic [NUM_PRIV-1:0][XLEN-1:0]       cause_bank;
   } arch_state_type;

endpackage

// ===== rtl/tidu_entry.sv =====
// Trap and interrupt entry logic: delegation, bank save, status update, vector target and status and privilege load.
module tidu_entry (
   input  tidu_pkg::req_type         req,
   input  tidu_pkg::csr_type         csr,
   input  tidu_pkg::arch_state_type  cur,
   output tidu_pkg::arch_state_type  nxt,
   output logic                      taken,
   output logic [tidu_pkg::XLEN-1:0] jump_pc
);

   logic [tidu_pkg::NUM_IRQ-1:0] irq_hit;
   logic                         irq_found;
   logic [3:0]                   irq_id;
   logic                         enter;
   logic                         is_int;
   logic [1:0]                   tgt;
   logic [tidu_pkg::XLEN-1:0]    epc_val;
   logic [tidu_pkg::XLEN-1:0]    cause_val;
   logic [tidu_pkg::XLEN-1:0]    vec;
   logic [tidu_pkg::XLEN-1:0]    vec_offset;

   function automatic logic [1:0] deleg_target(input logic [1:0] floor_lvl,
                                               input logic mach_bit,
                                               input logic sup_bit);
      logic [1:0] res;
      if (floor_lvl == tidu_pkg::PRIV_MACHINE || !mach_bit) begin
         res = tidu_pkg::PRIV_MACHINE;
      end else if (floor_lvl == tidu_pkg::PRIV_HYPER) begin
         res = tidu_pkg::PRIV_HYPER;
      end else if (floor_lvl == tidu_pkg::PRIV_SUPER || !sup_bit) begin
         res = tidu_pkg::PRIV_SUPER;
      end else begin
         res = tidu_pkg::PRIV_USER;
      end
      return res;
   endfunction

   always_comb begin
      logic [1:0] lvl;
      irq_hit = '0;
      for (int i = 1; i < tidu_pkg::NUM_IRQ; i++) begin
         lvl = 2'(i);
         irq_hit[i] = req.pending_bits[i] && req.enable_bits[i] &&
                      ((lvl > cur.priv_level) ||
                       ((lvl == cur.priv_level) && (cur.status_reg[lvl] || req.in_wfi)));
      end
   end

   always_comb begin
      irq_found = 1'b0;
      irq_id    = '0;
      for (int i = 1; i < tidu_pkg::NUM_IRQ; i++) begin
         if (irq_hit[i]) begin
            irq_found = 1'b1;
            irq_id    = 4'(i);
         end
      end
   end

   always_comb begin
      nxt        = cur;
      enter      = 1'b0;
      is_int     = 1'b0;
      tgt        = tidu_pkg::PRIV_MACHINE;
      epc_val    = req.current_pc;
      cause_val  = {27'd0, req.trap_cause};
      vec        = '0;
      vec_offset = '0;
      jump_pc    = req.current_pc;

      case (req.opcode)
         tidu_pkg::OP_TRAP: begin
            enter = 1'b1;
            tgt   = deleg_target(cur.priv_level, csr.mach_exc_deleg[req.trap_cause],
                                 csr.sup_exc_deleg[req.trap_cause]);
         end
         tidu_pkg::OP_INT_CHECK: begin
            enter     = irq_found;
            is_int    = 1'b1;
            tgt       = deleg_target(irq_id[1:0], csr.mach_int_deleg[irq_id],
                                     csr.sup_int_deleg[irq_id]);
            epc_val   = req.in_wfi ? req.current_pc + 32'd4 : req.current_pc;
            cause_val = {1'b1, 27'd0, irq_id};
         end
         tidu_pkg::OP_LOAD: begin
            nxt.status_reg = req.load_status;
            nxt.priv_level = req.load_priv;
         end
         default: begin
         end
      endcase

      unique case (tgt)
         tidu_pkg::PRIV_MACHINE: vec = csr.mach_vector;
         tidu_pkg::PRIV_SUPER:   vec = csr.sup_vector;
         tidu_pkg::PRIV_USER:    vec = csr.user_vector;
         default:                vec = '0;
      endcase
      if (is_int && vec[0]) begin
         vec_offset = {26'd0, irq_id, 2'b00};
      end

      if (enter) begin
         nxt.epc_bank[tgt]   = epc_val;
         nxt.cause_bank[tgt] = cause_val;
         if (tgt == tidu_pkg::PRIV_MACHINE) begin
            nxt.status_reg[tidu_pkg::ST_MPP +: 2] = cur.priv_level;
            nxt.status_reg[tidu_pkg::ST_MPIE]     = cur.status_reg[tidu_pkg::ST_MIE];
            nxt.status_reg[tidu_pkg::ST_MIE]      = 1'b0;
         end else if (tgt == tidu_pkg::PRIV_SUPER) begin
            nxt.status_reg[tidu_pkg::ST_SPP]  = cur.priv_level[0];
            nxt.status_reg[tidu_pkg::ST_SPIE] = cur.status_reg[tidu_pkg::ST_SIE];
            nxt.status_reg[tidu_pkg::ST_SIE]  = 1'b0;
         end
         nxt.priv_level = tgt;
         jump_pc        = {vec[tidu_pkg::XLEN-1:2], 2'b00} + vec_offset;
      end
   end

   assign taken = enter;

endmodule

// ===== rtl/trap_interrupt_delegation_unit.sv =====
// Top level of the trap and interrupt delegation unit.
//
// Request channel (req_valid, req_stall, req_data) carries one event per
// transaction: a synchronous trap, an interrupt check or a status and
// privilege load. Response channel (rsp_valid, rsp_stall, rsp_data) returns
// exactly one transaction per request with the entry decision, handler
// address, saved epc and cause of the resulting privilege and the new status.
// The csr_ port writes the delegation masks and trap vectors; write it only
// while no request is in flight.
// A request is registered at acceptance and evaluated from the input register;
// when it fires, the architectural state and the response register update
// together. One request per cycle is sustained while the receiver does not
// stall; the rate is set by the single evaluate stage that reads and writes
// the privilege, status and bank registers.
// When the receiver stalls, the response holds and one more request can wait
// in the input register before req_stall rises.
// Reset clears both channels, the masks, vectors, status and banks, and
// starts the hart in machine mode.
module trap_interrupt_delegation_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tidu_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tidu_pkg::rsp_type     rsp_data,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_index,
   input  logic [tidu_pkg::XLEN-1:0] csr_wdata
);

   logic                      req_valid_ff, req_valid_in;
   tidu_pkg::req_type         req_data_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   tidu_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   tidu_pkg::csr_type         csr_ff, csr_in;
   tidu_pkg::arch_state_type  state_ff, state_in, state_eval;
   logic                      fire;
   logic                      eval_taken;
   logic [tidu_pkg::XLEN-1:0] eval_jump;

   tidu_entry u_entry (
      .req     (req_data_ff),
      .csr     (csr_ff),
      .cur     (state_ff),
      .nxt     (state_eval),
      .taken   (eval_taken),
      .jump_pc (eval_jump)
   );

   assign fire      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      req_valid_in = (req_valid && !req_stall) || (req_valid_ff && !fire);
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
      state_in     = fire ? state_eval : state_ff;

      rsp_data_in.taken       = eval_taken;
      rsp_data_in.target_priv = state_eval.priv_level;
      rsp_data_in.jump_pc     = eval_jump;
      rsp_data_in.saved_epc   = state_eval.epc_bank[state_eval.priv_level];
      rsp_data_in.cause_word  = state_eval.cause_bank[state_eval.priv_level];
      rsp_data_in.status_word = state_eval.status_reg;

      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tidu_pkg::CSR_MACH_EXC_DELEG: csr_in.mach_exc_deleg = csr_wdata;
            tidu_pkg::CSR_SUP_EXC_DELEG:  csr_in.sup_exc_deleg  = csr_wdata;
            tidu_pkg::CSR_MACH_INT_DELEG: csr_in.mach_int_deleg = csr_wdata;
            tidu_pkg::CSR_SUP_INT_DELEG:  csr_in.sup_int_deleg  = csr_wdata;
            tidu_pkg::CSR_MACH_VECTOR:    csr_in.mach_vector    = csr_wdata;
            tidu_pkg::CSR_SUP_VECTOR:     csr_in.sup_vector     = csr_wdata;
            tidu_pkg::CSR_USER_VECTOR:    csr_in.user_vector    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff        <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         csr_ff              <= '0;
         state_ff.priv_level <= tidu_pkg::PRIV_MACHINE;
         state_ff.status_reg <= '0;
         state_ff.epc_bank   <= '0;
         state_ff.cause_bank <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         csr_ff       <= csr_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
